/* hw/rtl/adif_pkg.sv */
// ----------------------------------------------------------------------------
// ADIF parser package
// Shared transaction types, character constants and the field name ROM
// used by the tag/field parser and its name match cells.
// ----------------------------------------------------------------------------
package adif_pkg;

  // Default configuration of the parser.
  localparam int NUM_FIELDS      = 17;
  localparam int MAX_NAME_CHARS  = 16;
  localparam int MAX_VALUE_BYTES = 256;
  localparam int LENGTH_BITS     = 16;

  // Name ROM geometry and output field widths.
  localparam int ROM_CHARS     = 16;
  localparam int FIELD_INDEX_W = 5;
  localparam int COUNT_W       = 8;

  // Characters that delimit a tag.
  localparam logic [7:0] CH_TAG_OPEN  = 8'h3C;
  localparam logic [7:0] CH_TAG_CLOSE = 8'h3E;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;
  localparam logic [7:0] CH_DIGIT_9   = 8'h39;

  // End-of-record tag text, element 0 is the first character.
  localparam logic [0:2][7:0] EOR_TAG = "eor";

  // Input transaction: one datagram byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       datagram_end;
  } in_item_t;

  // Output transaction: one value byte and/or a field or record event.
  typedef struct packed {
    logic                     has_value_byte;
    logic [FIELD_INDEX_W-1:0] field_index;
    logic [7:0]               value_byte;
    logic                     field_done;
    logic                     value_truncated;
    logic                     record_done;
    logic                     ended_by_eor;
    logic [COUNT_W-1:0]       fields_found;
  } out_item_t;

  // Per-byte strobe shared by all name match cells.
  typedef struct packed {
    logic       start;
    logic       char_valid;
    logic [7:0] ch;
  } name_step_t;

  // Priority chain passed from cell to cell: first matching entry wins.
  typedef struct packed {
    logic                     found;
    logic [FIELD_INDEX_W-1:0] index;
  } match_chain_t;

  // ASCII upper case to lower case.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // Length of ROM entry idx; empty slots have length zero.
  function automatic int rom_len(input int idx);
    int n;
    case (idx)
      0, 1, 5:       n = 4;
      2, 6, 15:      n = 7;
      3, 4, 7, 13:   n = 8;
      8, 10, 12:     n = 10;
      9, 11:         n = 3;
      14:            n = 12;
      16:            n = 16;
      default:       n = 0;
    endcase
    return n;
  endfunction

  // Text of ROM entry idx, element k is character k.
  function automatic logic [ROM_CHARS-1:0][7:0] rom_text(input int idx);
    logic [8*ROM_CHARS-1:0]      s;
    logic [ROM_CHARS-1:0][7:0]   t;
    int                          n;
    s = '0;
    t = '0;
    n = rom_len(idx);
    case (idx)
      0:       s = "call";
      1:       s = "freq";
      2:       s = "freq_rx";
      3:       s = {"rst", "_sent"};
      4:       s = {"rst", "_rcvd"};
      5:       s = "mode";
      6:       s = "time_on";
      7:       s = {"time", "_off"};
      8:       s = {"stx", "_string"};
      9:       s = "stx";
      10:      s = {"srx", "_string"};
      11:      s = "srx";
      12:      s = {"contest", "_id"};
      13:      s = {"qso", "_date"};
      14:      s = {"qso", "_date", "_off"};
      15:      s = "comment";
      16:      s = {"station", "_callsign"};
      default: s = '0;
    endcase
    for (int k = 0; k < ROM_CHARS; k++) begin
      if (k < n) begin
        t[k] = s[8*(n-1-k) +: 8];
      end
    end
    return t;
  endfunction

endpackage

/* hw/rtl/adif_name_cell.sv */
// ----------------------------------------------------------------------------
// ADIF name match cell
// Tracks whether the tag name seen so far still equals one ROM entry and
// extends the first-match priority chain toward the next cell.
// ----------------------------------------------------------------------------
module adif_name_cell #(
  parameter int IDX            = 0,
  parameter int NAME_LEN_W     = 5,
  parameter int MAX_NAME_CHARS = adif_pkg::MAX_NAME_CHARS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  adif_pkg::name_step_t     step,
  input  logic [NAME_LEN_W-1:0]    pos,
  input  adif_pkg::match_chain_t   chain_in,
  output adif_pkg::match_chain_t   chain_out
);

  localparam int ROM_LEN    = adif_pkg::rom_len(IDX);
  localparam bit ENABLED    = (ROM_LEN > 0) && (ROM_LEN <= MAX_NAME_CHARS);
  localparam int CHAR_IDX_W = $clog2(adif_pkg::ROM_CHARS);
  localparam logic [NAME_LEN_W-1:0] LEN_CODE = ENABLED ? NAME_LEN_W'(ROM_LEN) : '0;
  localparam logic [adif_pkg::ROM_CHARS-1:0][7:0] TEXT = adif_pkg::rom_text(IDX);

  logic       alive;
  logic [7:0] expected;
  logic       hit;

  // ROM character at the current name position.
  assign expected = TEXT[CHAR_IDX_W'(pos)];

  // The entry stays alive while every name character agrees with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (step.start) begin
      alive <= 1'b1;
    end else if (step.char_valid) begin
      if (pos >= LEN_CODE || step.ch != expected) begin
        alive <= 1'b0;
      end
    end
  end

  // Exact match needs the full entry length as well.
  assign hit = ENABLED && alive && (pos == LEN_CODE);

  // Earlier cells have priority over this one.
  always_comb begin
    chain_out.found = chain_in.found | hit;
    chain_out.index = chain_in.found ? chain_in.index
                                     : adif_pkg::FIELD_INDEX_W'(IDX);
  end

endmodule

/* hw/rtl/adif_tag_field_parser.sv */
// ----------------------------------------------------------------------------
// ADIF tag/field parser
// Parses <name:length[:type]>value records from a byte stream and emits
// the value bytes and field end events of known fields plus record end events.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the char channel (char_valid/char_ready/char_data), one
//   transaction per byte, datagram_end set on the last byte of a datagram.
//   Results leave on the field channel (field_valid/field_ready/field_data).
//   A byte produces zero or one result transaction.
//   A result is registered and presented in the cycle after its byte is accepted.
//   One byte per cycle unless the output stalls. Each byte updates the tag
//   state and the row of name match cells in the cycle it is accepted; the match
//   result is read from the cell chain when the closing '>' arrives.
//   The output register holds one result. While it is full and the receiver
//   stalls, char_ready is low; when the receiver takes it, a new byte is
//   accepted in the same cycle.
//   Reset (rst, synchronous) returns the parser to scanning for a tag,
//   clears the matched field count and empties the output register.
//   No warm-up is needed after reset.
// ----------------------------------------------------------------------------
module adif_tag_field_parser #(
  parameter int NUM_FIELDS      = adif_pkg::NUM_FIELDS,
  parameter int MAX_NAME_CHARS  = adif_pkg::MAX_NAME_CHARS,
  parameter int MAX_VALUE_BYTES = adif_pkg::MAX_VALUE_BYTES,
  parameter int LENGTH_BITS     = adif_pkg::LENGTH_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  adif_pkg::in_item_t  char_data,
  output logic                field_valid,
  input  logic                field_ready,
  output adif_pkg::out_item_t field_data
);

  localparam int NAME_LEN_W = $clog2(MAX_NAME_CHARS + 2);
  localparam int POS_W      = $clog2(MAX_VALUE_BYTES + 1);
  localparam int IDX_W      = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
  localparam int PROD_W     = LENGTH_BITS + 4;

  localparam logic [NAME_LEN_W-1:0] NAME_MAX   = NAME_LEN_W'(MAX_NAME_CHARS);
  localparam logic [NAME_LEN_W-1:0] NAME_OVER  = NAME_LEN_W'(MAX_NAME_CHARS + 1);
  localparam logic [NAME_LEN_W-1:0] EOR_LEN    = NAME_LEN_W'(3);
  localparam logic [POS_W-1:0]      VALUE_LIMIT = POS_W'(MAX_VALUE_BYTES);
  localparam logic [POS_W-1:0]      VALUE_LAST  = POS_W'(MAX_VALUE_BYTES - 1);
  localparam logic [LENGTH_BITS-1:0] LEN_SAT   = '1;
  localparam logic [adif_pkg::COUNT_W-1:0] COUNT_SAT = '1;

  // Parser phases.
  localparam logic [1:0] PH_SCAN  = 2'd0;
  localparam logic [1:0] PH_TAG   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DRAIN = 2'd3;

  // Parser state.
  logic [1:0]                   phase, phase_next;
  logic [NAME_LEN_W-1:0]        name_length, name_length_next;
  logic                         colon_seen, colon_seen_next;
  logic                         digits_active, digits_active_next;
  logic                         eor_ok, eor_ok_next;
  logic [LENGTH_BITS-1:0]       remaining, remaining_next;
  logic [POS_W-1:0]             value_position, value_position_next;
  logic [IDX_W-1:0]             current_field, current_field_next;
  logic                         field_matched, field_matched_next;
  logic [adif_pkg::COUNT_W-1:0] matched_count, matched_count_next;

  logic                 accept;
  logic                 emit;
  adif_pkg::out_item_t  result;
  adif_pkg::name_step_t step;
  logic                 name_char;
  logic                 tag_start;
  logic [7:0]           b;
  logic [7:0]           b_lower;
  logic [PROD_W-1:0]    length_prod;
  logic                 value_done;

  adif_pkg::match_chain_t chain [NUM_FIELDS+1];

  assign accept     = char_valid && char_ready;
  assign char_ready = !field_valid || field_ready;
  assign b          = char_data.data_byte;
  assign b_lower    = adif_pkg::to_lower(b);

  // Decimal length accumulation: remaining * 10 + digit.
  assign length_prod = (PROD_W'(remaining) << 3) + (PROD_W'(remaining) << 1)
                     + PROD_W'(b - adif_pkg::CH_DIGIT_0);

  assign value_done = (remaining == LENGTH_BITS'(1)) || (value_position == VALUE_LAST);

  // Row of name match cells, one per ROM entry.
  assign step.start      = accept && tag_start;
  assign step.char_valid = accept && name_char;
  assign step.ch         = b_lower;
  assign chain[0]        = '0;

  for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_cell
    adif_name_cell #(
      .IDX            (g),
      .NAME_LEN_W     (NAME_LEN_W),
      .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (step),
      .pos       (name_length),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  // Next-state and result for one byte.
  always_comb begin
    phase_next          = phase;
    name_length_next    = name_length;
    colon_seen_next     = colon_seen;
    digits_active_next  = digits_active;
    eor_ok_next         = eor_ok;
    remaining_next      = remaining;
    value_position_next = value_position;
    current_field_next  = current_field;
    field_matched_next  = field_matched;
    matched_count_next  = matched_count;
    emit                = 1'b0;
    result              = '0;
    name_char           = 1'b0;
    tag_start           = 1'b0;

    unique case (phase)
      PH_SCAN: begin
        if (b == adif_pkg::CH_TAG_OPEN) begin
          phase_next         = PH_TAG;
          name_length_next   = '0;
          colon_seen_next    = 1'b0;
          digits_active_next = 1'b0;
          eor_ok_next        = 1'b1;
          remaining_next     = '0;
          tag_start          = 1'b1;
        end
      end
      PH_TAG: begin
        if (b == adif_pkg::CH_TAG_CLOSE) begin
          if (eor_ok && name_length >= EOR_LEN) begin
            // End-of-record tag.
            emit                = 1'b1;
            result.record_done  = 1'b1;
            result.ended_by_eor = 1'b1;
            result.fields_found = matched_count;
            matched_count_next  = '0;
            phase_next          = PH_DRAIN;
          end else if (!colon_seen) begin
            phase_next = PH_SCAN;
          end else begin
            field_matched_next  = chain[NUM_FIELDS].found;
            current_field_next  = IDX_W'(chain[NUM_FIELDS].index);
            value_position_next = '0;
            if (chain[NUM_FIELDS].found && matched_count != COUNT_SAT) begin
              matched_count_next = matched_count + 1'b1;
            end
            if (remaining == '0) begin
              if (chain[NUM_FIELDS].found) begin
                emit               = 1'b1;
                result.field_index = chain[NUM_FIELDS].index;
                result.field_done  = 1'b1;
              end
              phase_next = PH_SCAN;
            end else begin
              phase_next = PH_VALUE;
            end
          end
        end else if (!colon_seen) begin
          if (b == adif_pkg::CH_COLON) begin
            colon_seen_next    = 1'b1;
            digits_active_next = 1'b1;
          end else begin
            name_char = 1'b1;
            if (name_length < EOR_LEN) begin
              eor_ok_next = eor_ok && (b_lower == adif_pkg::EOR_TAG[2'(name_length)]);
            end
            if (name_length < NAME_MAX) begin
              name_length_next = name_length + 1'b1;
            end else begin
              name_length_next = NAME_OVER;
            end
          end
        end else if (digits_active) begin
          if (b >= adif_pkg::CH_DIGIT_0 && b <= adif_pkg::CH_DIGIT_9) begin
            if (length_prod[PROD_W-1:LENGTH_BITS] != '0) begin
              remaining_next = LEN_SAT;
            end else begin
              remaining_next = length_prod[LENGTH_BITS-1:0];
            end
          end else begin
            digits_active_next = 1'b0;
          end
        end
      end
      PH_VALUE: begin
        if (field_matched && value_position < VALUE_LIMIT) begin
          emit                   = 1'b1;
          result.has_value_byte  = 1'b1;
          result.field_index     = adif_pkg::FIELD_INDEX_W'(current_field);
          result.value_byte      = b;
          result.field_done      = value_done;
          result.value_truncated = value_done && (remaining > LENGTH_BITS'(1));
          value_position_next    = value_position + 1'b1;
        end
        remaining_next = remaining - 1'b1;
        if (remaining == LENGTH_BITS'(1)) begin
          phase_next = PH_SCAN;
        end
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    // Datagram end closes the record unless an EOR tag already did.
    if (char_data.datagram_end) begin
      if (phase_next != PH_DRAIN) begin
        emit                = 1'b1;
        result.record_done  = 1'b1;
        result.ended_by_eor = 1'b0;
        result.fields_found = matched_count_next;
        matched_count_next  = '0;
      end
      phase_next = PH_SCAN;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      name_length    <= '0;
      colon_seen     <= 1'b0;
      digits_active  <= 1'b0;
      eor_ok         <= 1'b0;
      remaining      <= '0;
      value_position <= '0;
      current_field  <= '0;
      field_matched  <= 1'b0;
      matched_count  <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      name_length    <= name_length_next;
      colon_seen     <= colon_seen_next;
      digits_active  <= digits_active_next;
      eor_ok         <= eor_ok_next;
      remaining      <= remaining_next;
      value_position <= value_position_next;
      current_field  <= current_field_next;
      field_matched  <= field_matched_next;
      matched_count  <= matched_count_next;
    end
  end

  // Output register: a new result takes priority over emptying it.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_valid <= 1'b0;
    end else if (accept && emit) begin
      field_valid <= 1'b1;
    end else if (field_ready) begin
      field_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      field_data <= result;
    end
  end

  // A record end caused by an EOR tag is always flagged as a record end.
  a_eor_is_record: assert property (@(posedge clk) disable iff (rst)
    field_valid && field_data.ended_by_eor |-> field_data.record_done)
    else $error("ended_by_eor without record_done");

  // Truncation is only reported on the last emitted byte of a field.
  a_trunc_on_last: assert property (@(posedge clk) disable iff (rst)
    field_valid && field_data.value_truncated |->
      field_data.field_done && field_data.has_value_byte)
    else $error("value_truncated outside a final value byte");

  // The matched count is only reported with a record end.
  a_count_only_at_end: assert property (@(posedge clk) disable iff (rst)
    field_valid && !field_data.record_done |-> field_data.fields_found == '0)
    else $error("fields_found nonzero without record_done");

  // A datagram end always returns the parser to tag scanning.
  a_end_to_scan: assert property (@(posedge clk) disable iff (rst)
    accept && char_data.datagram_end |=> phase == PH_SCAN)
    else $error("parser not scanning after datagram end");

  // The value phase always has bytes left to consume.
  a_value_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_VALUE |-> remaining != '0)
    else $error("value phase with no remaining bytes");

endmodule
